FILE: hw/rtl/tcw_pkg.sv
// tcw_pkg: shared types and constants for the text console writer.
// Request and response payload structs, function codes, character codes.
// No dependencies.
package tcw_pkg;

   // Default geometry
   localparam int COLS_DEFAULT     = 80;
   localparam int ROWS_DEFAULT     = 25;
   localparam int TAB_STOP_DEFAULT = 8;

   // Payload field widths
   localparam int FUNC_W  = 2;
   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 11;
   localparam int CELL_W  = 16;
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int ATTR_W  = 8;

   typedef logic [FUNC_W-1:0]  func_type;
   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [CELL_W-1:0]  cell_type;
   typedef logic [ROW_W-1:0]   row_field_type;
   typedef logic [COL_W-1:0]   col_field_type;
   typedef logic [ATTR_W-1:0]  attr_type;

   // Function codes
   localparam func_type FUNC_PUT    = 2'd0;
   localparam func_type FUNC_BACK   = 2'd1;
   localparam func_type FUNC_TOGGLE = 2'd2;
   localparam func_type FUNC_READ   = 2'd3;

   // Character codes
   localparam char_type CH_SPACE   = 8'h20;
   localparam char_type CH_NEWLINE = 8'h0A;
   localparam char_type CH_TAB     = 8'h09;

   // Attributes
   localparam attr_type ATTR_TEXT_RESET = 8'h07;
   localparam attr_type ATTR_CURSOR_HI  = 8'hF0;
   localparam attr_type ATTR_CURSOR_LO  = 8'h0F;
   localparam logic [3:0] NIBBLE_FULL   = 4'hF;
   localparam cell_type CELL_RESET      = 16'h0720;

   typedef struct packed {
      func_type  func;
      char_type  ch;
      index_type cell_index;
   } req_type;

   typedef struct packed {
      cell_type      read_data;
      row_field_type cursor_row;
      col_field_type cursor_col;
   } rsp_type;

endpackage

FILE: hw/rtl/tcw_cell_ram.sv
// tcw_cell_ram: character cell buffer, one write port and one read port.
// Read data registered. Uses tcw_pkg for the cell type.
module tcw_cell_ram #(
   parameter int ADDR_W = 11,
   parameter int DEPTH  = 2000
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  tcw_pkg::cell_type    wr_data,
   input  logic [ADDR_W-1:0]    rd_addr,
   output tcw_pkg::cell_type    rd_data
);

   tcw_pkg::cell_type mem [DEPTH];
   tcw_pkg::cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/text_console_writer.sv
// text_console_writer: text terminal, ROWS x COLS cells in one RAM; uses tcw_pkg, tcw_cell_ram.
// Each request ends in a result strobe; a tab puts one cell per padding position and a
// scroll copies every row up by one, blanking the bottom row in the text color.
// Throughput: one request at a time, busy high until its result strobes.
// Reset: a clearing pass writes every cell with busy high.
// The receiver cannot stall; each result is strobed for one cycle.
module text_console_writer #(
   parameter int COLS     = tcw_pkg::COLS_DEFAULT,
   parameter int ROWS     = tcw_pkg::ROWS_DEFAULT,
   parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              start,
   output logic              busy,
   input  tcw_pkg::req_type  req_item,
   // response channel
   output logic              rsp_valid,
   output tcw_pkg::rsp_type  rsp_item,
   // text color register
   input  logic              csr_wr_en,
   input  tcw_pkg::attr_type csr_wr_data
);

   localparam int NCELLS   = ROWS * COLS;
   localparam int AW       = $clog2(NCELLS);
   localparam int RW       = (ROWS > 2) ? $clog2(ROWS) : 1;
   localparam int CW       = $clog2(COLS);
   localparam int PW       = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
   localparam int TW       = $clog2(TAB_STOP + 1);
   localparam int LAST_BASE = (ROWS - 1) * COLS;     // first cell of the bottom row
   localparam int WRAP_PHASE = (COLS - 1) % TAB_STOP; // tab phase of the last column

   typedef logic [AW-1:0] addr_type;
   typedef logic [RW-1:0] row_type;
   typedef logic [CW-1:0] col_type;
   typedef logic [PW-1:0] phase_type;
   typedef logic [TW-1:0] tab_type;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CLEAR  = 8'b0000_0010,
      ST_PUT    = 8'b0000_0100,
      ST_SCROLL = 8'b0000_1000,
      ST_FILL   = 8'b0001_0000,
      ST_BACK   = 8'b0010_0000,
      ST_DRAW   = 8'b0100_0000,
      ST_READ   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // cursor and attributes
   row_type           row_ff, row_in;
   col_type           col_ff, col_in;
   phase_type         phase_ff, phase_in;    // col % TAB_STOP, tracked incrementally
   tcw_pkg::attr_type attr_ff, attr_in;      // cursor attribute
   tcw_pkg::attr_type color_ff;              // text color register

   // request context
   tab_type            tab_ff, tab_in;       // remaining cells to put
   tcw_pkg::char_type  ch_ff, ch_in;
   tcw_pkg::index_type idx_ff, idx_in;

   // scan pointer for clear, scroll and fill passes
   addr_type scan_ff, scan_in;
   logic     pend_ff, pend_in;               // scroll: read data waiting to be written
   addr_type waddr_ff, waddr_in;             // scroll: target of the waiting data

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_type rsp_ff, rsp_in;

   // RAM ports
   logic              mem_we;
   addr_type          mem_waddr;
   tcw_pkg::cell_type mem_wdata;
   addr_type          mem_raddr;
   tcw_pkg::cell_type mem_rdata;

   addr_type          cursor_addr;
   logic              last_col, last_row, is_nl;
   tcw_pkg::char_type put_ch;
   phase_type         phase_next;

   tcw_cell_ram #(
      .ADDR_W (AW),
      .DEPTH  (NCELLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign cursor_addr = addr_type'(row_ff * COLS) + addr_type'(col_ff);
   assign last_col    = (col_ff == col_type'(COLS - 1));
   assign last_row    = (row_ff == row_type'(ROWS - 1));
   assign is_nl       = (ch_ff == tcw_pkg::CH_NEWLINE);
   assign put_ch      = (ch_ff == tcw_pkg::CH_TAB) ? tcw_pkg::CH_SPACE : ch_ff;
   assign phase_next  = (phase_ff == phase_type'(TAB_STOP - 1)) ? '0 : phase_ff + 1'b1;

   // read port: request index while idle, row below during a scroll
   always_comb begin
      if (state_ff == ST_SCROLL) begin
         mem_raddr = scan_ff + addr_type'(COLS);
      end else begin
         mem_raddr = addr_type'(req_item.cell_index);
      end
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      phase_in     = phase_ff;
      attr_in      = attr_ff;
      tab_in       = tab_ff;
      ch_in        = ch_ff;
      idx_in       = idx_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      waddr_in     = waddr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = cursor_addr;
      mem_wdata    = {color_ff, tcw_pkg::CH_SPACE};

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff;
            mem_wdata = tcw_pkg::CELL_RESET;
            scan_in   = scan_ff + 1'b1;
            if (scan_ff == addr_type'(NCELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (start) begin
               ch_in  = req_item.ch;
               idx_in = req_item.cell_index;
               unique case (req_item.func)
                  tcw_pkg::FUNC_PUT: begin
                     // a tab pads to the next stop, anything else is one cell
                     if (req_item.ch == tcw_pkg::CH_TAB) begin
                        tab_in = tab_type'(TAB_STOP) - tab_type'(phase_ff);
                     end else begin
                        tab_in = tab_type'(1);
                     end
                     state_in = ST_PUT;
                  end
                  tcw_pkg::FUNC_BACK: begin
                     state_in = ST_BACK;
                  end
                  tcw_pkg::FUNC_TOGGLE: begin
                     if (attr_ff[3:0] == tcw_pkg::NIBBLE_FULL) begin
                        attr_in = tcw_pkg::ATTR_CURSOR_HI;
                     end else begin
                        attr_in = tcw_pkg::ATTR_CURSOR_LO;
                     end
                     state_in = ST_DRAW;
                  end
                  tcw_pkg::FUNC_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_PUT: begin
            // one cell per cycle unless a scroll intervenes; a wrap past the last column leaves no blank write
            mem_we  = 1'b1;
            scan_in = '0;
            if (is_nl) begin
               tab_in   = '0;
               col_in   = '0;
               phase_in = '0;
               if (last_row) begin
                  state_in = ST_SCROLL;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = ST_DRAW;
               end
            end else begin
               mem_wdata = {color_ff, put_ch};
               tab_in    = tab_ff - 1'b1;
               if (last_col) begin
                  col_in   = '0;
                  phase_in = '0;
               end else begin
                  col_in   = col_ff + 1'b1;
                  phase_in = phase_next;
               end
               if (last_col && last_row) begin
                  state_in = ST_SCROLL;
               end else begin
                  if (last_col) begin
                     row_in = row_ff + 1'b1;
                  end
                  state_in = (tab_ff != tab_type'(1)) ? ST_PUT : ST_DRAW;
               end
            end
         end

         ST_SCROLL: begin
            // read cell i+COLS, write it to cell i in the following cycle
            mem_we    = pend_ff;
            mem_waddr = waddr_ff;
            mem_wdata = mem_rdata;
            if (scan_ff == addr_type'(LAST_BASE)) begin
               state_in = ST_FILL;
            end else begin
               pend_in  = 1'b1;
               waddr_in = scan_ff;
               scan_in  = scan_ff + 1'b1;
            end
         end

         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff;
            scan_in   = scan_ff + 1'b1;
            if (scan_ff == addr_type'(NCELLS - 1)) begin
               state_in = (tab_ff != '0) ? ST_PUT : ST_DRAW;
            end
         end

         ST_BACK: begin
            mem_we = 1'b1;
            if (col_ff != '0) begin
               col_in   = col_ff - 1'b1;
               phase_in = (phase_ff == '0) ? phase_type'(TAB_STOP - 1) : phase_ff - 1'b1;
            end else if (row_ff != '0) begin
               col_in   = col_type'(COLS - 1);
               phase_in = phase_type'(WRAP_PHASE);
               row_in   = row_ff - 1'b1;
            end
            state_in = ST_DRAW;
         end

         ST_DRAW: begin
            mem_we                = 1'b1;
            mem_wdata             = {attr_ff, tcw_pkg::CH_SPACE};
            rsp_valid_in          = 1'b1;
            rsp_in.read_data      = '0;
            rsp_in.cursor_row     = tcw_pkg::row_field_type'(row_ff);
            rsp_in.cursor_col     = tcw_pkg::col_field_type'(col_ff);
            state_in              = ST_IDLE;
         end

         ST_READ: begin
            rsp_valid_in = 1'b1;
            if (32'(idx_ff) < NCELLS) begin
               rsp_in.read_data = mem_rdata;
            end else begin
               rsp_in.read_data = '0;
            end
            rsp_in.cursor_row = tcw_pkg::row_field_type'(row_ff);
            rsp_in.cursor_col = tcw_pkg::col_field_type'(col_ff);
            state_in          = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         col_ff       <= '0;
         phase_ff     <= '0;
         attr_ff      <= tcw_pkg::ATTR_CURSOR_HI;
         color_ff     <= tcw_pkg::ATTR_TEXT_RESET;
         tab_ff       <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         phase_ff     <= phase_in;
         attr_ff      <= attr_in;
         tab_ff       <= tab_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            color_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ch_ff    <= ch_in;
      idx_ff   <= idx_in;
      waddr_ff <= waddr_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

FILE: tb/sv/tcw_sb_pkg.sv
`timescale 1ns / 1ps
// tcw_sb_pkg: response scoreboard for the text console writer bench.
// Mirrors screen, cursor and color state to predict each response; needs tcw_pkg.
package tcw_sb_pkg;
   import tcw_pkg::*;

   localparam int SCR_COLS  = COLS_DEFAULT;
   localparam int SCR_ROWS  = ROWS_DEFAULT;
   localparam int SCR_TAB   = TAB_STOP_DEFAULT;
   localparam int SCR_CELLS = SCR_COLS * SCR_ROWS;

   class console_scoreboard;
      cell_type    screen[SCR_CELLS];
      int unsigned cur_row;
      int unsigned cur_col;
      attr_type    cursor_attr;
      attr_type    text_attr;
      rsp_type     expected_rsps[$];
      int unsigned errors;
      int unsigned matched;
      int unsigned scrolls;

      function new();
         foreach (screen[i]) screen[i] = CELL_RESET;
         cur_row     = 0;
         cur_col     = 0;
         cursor_attr = ATTR_CURSOR_HI;
         text_attr   = ATTR_TEXT_RESET;
         errors      = 0;
         matched     = 0;
         scrolls     = 0;
      endfunction

      function void set_text_color(attr_type color);
         text_attr = color;
      endfunction

      // off-screen writes are dropped
      function void poke(char_type c, attr_type a, int unsigned x, int unsigned y);
         if (y < SCR_ROWS && x < SCR_COLS) screen[y * SCR_COLS + x] = {a, c};
      endfunction

      function void draw_cursor();
         poke(CH_SPACE, cursor_attr, cur_col, cur_row);
      endfunction

      function void scroll_screen();
         for (int i = 0; i < SCR_CELLS - SCR_COLS; i++) screen[i] = screen[i + SCR_COLS];
         for (int i = SCR_CELLS - SCR_COLS; i < SCR_CELLS; i++) screen[i] = {text_attr, CH_SPACE};
         if (cur_row > 0) cur_row--;
         scrolls++;
      endfunction

      function void line_feed();
         poke(CH_SPACE, text_attr, cur_col, cur_row);
         cur_col = 0;
         cur_row++;
         if (cur_row >= SCR_ROWS) scroll_screen();
      endfunction

      function void put_glyph(char_type c);
         poke(c, text_attr, cur_col, cur_row);
         cur_col++;
         if (cur_col >= SCR_COLS) line_feed();
      endfunction

      // called once per accepted request, in acceptance order
      function void note_request(req_type r);
         rsp_type     exp;
         int unsigned pad;
         exp = '0;
         case (r.func)
            FUNC_PUT: begin
               if (r.ch == CH_NEWLINE) begin
                  line_feed();
               end else if (r.ch == CH_TAB) begin
                  pad = SCR_TAB - cur_col % SCR_TAB;
                  repeat (pad) begin
                     put_glyph(CH_SPACE);
                     draw_cursor();
                  end
               end else begin
                  put_glyph(r.ch);
               end
               draw_cursor();
            end
            FUNC_BACK: begin
               poke(CH_SPACE, text_attr, cur_col, cur_row);
               if (cur_col != 0) begin
                  cur_col--;
               end else if (cur_row != 0) begin
                  cur_col = SCR_COLS - 1;
                  cur_row--;
               end
               draw_cursor();
            end
            FUNC_TOGGLE: begin
               cursor_attr = (cursor_attr[3:0] == NIBBLE_FULL) ? ATTR_CURSOR_HI : ATTR_CURSOR_LO;
               draw_cursor();
            end
            FUNC_READ: begin
               if (r.cell_index < SCR_CELLS) exp.read_data = screen[r.cell_index];
            end
         endcase
         exp.cursor_row = row_field_type'(cur_row);
         exp.cursor_col = col_field_type'(cur_col);
         expected_rsps.push_back(exp);
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp;
         bit      ok;
         if (expected_rsps.size() == 0) begin
            $display("%0t tb: response with none pending, expected none, got %h", $time, got);
            errors++;
            return;
         end
         exp = expected_rsps.pop_front();
         ok  = 1'b1;
         if (got.read_data !== exp.read_data) begin
            $display("%0t tb: read_data mismatch, expected %h, got %h",
                     $time, exp.read_data, got.read_data);
            ok = 1'b0;
         end
         if (got.cursor_row !== exp.cursor_row) begin
            $display("%0t tb: cursor_row mismatch, expected %0d, got %0d",
                     $time, exp.cursor_row, got.cursor_row);
            ok = 1'b0;
         end
         if (got.cursor_col !== exp.cursor_col) begin
            $display("%0t tb: cursor_col mismatch, expected %0d, got %0d",
                     $time, exp.cursor_col, got.cursor_col);
            ok = 1'b0;
         end
         if (ok) matched++;
         else errors++;
      endfunction
   endclass

endpackage

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: top-level bench for text_console_writer; drives requests and color writes,
// checks every strobed response against tcw_sb_pkg. Needs tcw_pkg and the RTL.
module tb;
   import tcw_pkg::*;
   import tcw_sb_pkg::*;

   // Worst case for a correct run is every request scrolling, plus the longest gaps
   // and the post-reset clear.
   localparam int unsigned LIMIT_CYCLES  = 16_000_000;
   // quiet cycles after the last response before touching the register
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned PHASE_REQS    = 350;

   logic     clock       = 1'b0;
   logic     reset       = 1'b1;
   logic     start       = 1'b0;
   logic     busy;
   req_type  req_item    = '0;
   logic     rsp_valid;
   rsp_type  rsp_item;
   logic     csr_wr_en   = 1'b0;
   attr_type csr_wr_data = ATTR_TEXT_RESET;

   console_scoreboard sb = new();

   int unsigned n_cycles   = 0;
   int unsigned n_sent     = 0;
   int unsigned n_reads    = 0;
   int unsigned n_colors   = 0;
   int unsigned burst_left = 0;
   bit          gaps_on    = 1'b1;
   bit          start_held = 1'b0;   // mirrors the pending value of start

   text_console_writer i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Responses cannot be held off: every strobe is checked at the edge that ends it.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_response(rsp_item);
   end

   // Watchdog
   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (n_cycles == LIMIT_CYCLES) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   function automatic req_type mk(func_type f, char_type c, index_type i);
      return '{func: f, ch: c, cell_index: i};
   endfunction

   // index is don't-care except on reads; keep it toggling anyway
   function automatic index_type any_index();
      return index_type'($urandom_range(0, 2047));
   endfunction

   // mostly printable text, sometimes any byte (newline and tab included)
   function automatic char_type text_byte();
      if ($urandom_range(0, 9) == 0) return char_type'($urandom_range(0, 255));
      return char_type'($urandom_range(32, 126));
   endfunction

   // Hold start until the request is taken (start high, busy low at an edge).
   // When gaps are on, requests go out in bursts with idle stretches between.
   task automatic send_request(req_type r);
      start      <= 1'b1;
      start_held  = 1'b1;
      req_item   <= r;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(r);
      n_sent++;
      if (r.func == FUNC_READ) n_reads++;
      if (gaps_on) begin
         if (burst_left == 0) begin
            start      <= 1'b0;
            start_held  = 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
            burst_left = $urandom_range(1, 30);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Drop start and wait for every pending response, then idle quietly before returning.
   task automatic settle();
      if (start_held) begin
         start      <= 1'b0;
         start_held  = 1'b0;
      end
      while (sb.expected_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_text_color(attr_type color);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= color;
      @(posedge clock);
      sb.set_text_color(color);
      csr_wr_en   <= 1'b0;
      n_colors++;
   endtask

   // Directed corners: reset contents, out-of-range reads, byte extremes,
   // backspace at home and across a row, wrap at the last column, tabs.
   task automatic directed_requests();
      send_request(mk(FUNC_READ, 8'h00, 11'd0));        // reset cell
      send_request(mk(FUNC_READ, 8'hFF, 11'd1999));     // last cell
      send_request(mk(FUNC_READ, 8'h00, 11'd2000));     // just past the buffer
      send_request(mk(FUNC_READ, 8'hFF, 11'h7FF));      // top of index range
      send_request(mk(FUNC_BACK, 8'h00, 11'h7FF));      // at home: stays put
      send_request(mk(FUNC_PUT, 8'h41, 11'd0));
      send_request(mk(FUNC_PUT, 8'hFF, 11'd0));
      send_request(mk(FUNC_PUT, 8'h80, 11'd0));         // high byte stored as-is
      send_request(mk(FUNC_PUT, 8'h00, 11'd0));
      send_request(mk(FUNC_PUT, CH_SPACE, 11'd0));
      send_request(mk(FUNC_TOGGLE, 8'h00, 11'd0));
      send_request(mk(FUNC_TOGGLE, 8'h00, 11'd0));      // back to the first color
      send_request(mk(FUNC_PUT, CH_TAB, 11'd0));        // col 5 -> 8
      send_request(mk(FUNC_PUT, CH_TAB, 11'd0));        // full stop of padding
      send_request(mk(FUNC_PUT, CH_NEWLINE, 11'd0));
      send_request(mk(FUNC_BACK, 8'h00, 11'd0));        // col 0 -> end of row above
      send_request(mk(FUNC_PUT, 8'h7A, 11'd0));         // last column: wraps
      send_request(mk(FUNC_READ, 8'h00, 11'd79));
      send_request(mk(FUNC_READ, 8'h00, 11'd80));       // cursor cell
      send_request(mk(FUNC_BACK, 8'h00, 11'd0));
      send_request(mk(FUNC_READ, 8'h00, 11'd79));
      send_request(mk(FUNC_PUT, CH_NEWLINE, 11'd0));    // newline from the last column
      send_request(mk(FUNC_READ, 8'h00, 11'd1));
      send_request(mk(FUNC_READ, 8'h00, 11'd2));
   endtask

   // Random traffic built from plausible terminal activity: text lines,
   // tab runs, backspace runs, reads around the cursor, toggles, blank lines,
   // and some unstructured noise.
   task automatic random_traffic(int unsigned n_req);
      int unsigned stop_at;
      int unsigned pick;
      int unsigned len;
      int unsigned here;
      int unsigned off;
      stop_at = n_sent + n_req;
      while (n_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            len = $urandom_range(1, 60);
            repeat (len) send_request(mk(FUNC_PUT, text_byte(), any_index()));
            if ($urandom_range(0, 3) != 0)
               send_request(mk(FUNC_PUT, CH_NEWLINE, any_index()));
         end else if (pick < 55) begin
            repeat ($urandom_range(1, 4)) send_request(mk(FUNC_PUT, CH_TAB, any_index()));
         end else if (pick < 65) begin
            repeat ($urandom_range(1, 12))
               send_request(mk(FUNC_BACK, char_type'($urandom_range(0, 255)), any_index()));
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 1) == 0) begin
                  // just behind the cursor, where the latest writes landed
                  here = sb.cur_row * SCR_COLS + sb.cur_col;
                  off  = $urandom_range(0, 2);
                  if (here >= off) here = here - off;
                  send_request(mk(FUNC_READ, char_type'($urandom_range(0, 255)),
                                  index_type'(here)));
               end else begin
                  send_request(mk(FUNC_READ, char_type'($urandom_range(0, 255)),
                                  any_index()));
               end
            end
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 3))
               send_request(mk(FUNC_TOGGLE, char_type'($urandom_range(0, 255)), any_index()));
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 3)) send_request(mk(FUNC_PUT, CH_NEWLINE, any_index()));
         end else begin
            repeat ($urandom_range(1, 8))
               send_request(mk(func_type'($urandom_range(0, 3)),
                               char_type'($urandom_range(0, 255)), any_index()));
         end
      end
   endtask

   // Each phase starts idle: all responses in, then a new text color.
   task automatic run_phase(attr_type color, bit with_gaps);
      settle();
      write_text_color(color);
      gaps_on    = with_gaps;
      burst_left = $urandom_range(0, 30);
      random_traffic(PHASE_REQS);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // clearing pass after reset keeps busy high
      while (busy !== 1'b0) @(posedge clock);

      write_text_color(8'h4E);
      directed_requests();

      run_phase(8'h00, 1'b1);
      run_phase(8'hFF, 1'b0);                          // back-to-back, no gaps
      run_phase(attr_type'($urandom_range(0, 255)), 1'b1);
      run_phase(8'h1E, 1'b1);
      run_phase(attr_type'($urandom_range(0, 255)), 1'b1);

      settle();
      $display("tb: %0d requests (%0d reads), %0d responses matched, %0d scrolls",
               n_sent, n_reads, sb.matched, sb.scrolls);
      $display("tb: %0d text color writes, %0d cycles", n_colors, n_cycles);
      if (sb.errors == 0 && sb.expected_rsps.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_cell_ram.sv
hw/rtl/text_console_writer.sv
tb/sv/tcw_sb_pkg.sv
tb/sv/tb.sv
